[sv/der_pkg.sv]
// Package for the disk elevator request scheduler.
// Holds the request, result and entry types and the status codes; no dependencies.
package der_pkg;

	localparam int unsigned TRACK_W = 16;
	localparam logic [TRACK_W-1:0] TRACK_MAX = '1;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DISPATCH = 2'd2,
		ST_IDLE     = 2'd3
	} status_t;

	localparam logic CMD_ENQUEUE  = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] req_track;
		logic [3:0]  req_first_block;
		logic [7:0]  req_block_count;
		logic        req_kind;
		logic [5:0]  req_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  out_tag;
		logic        out_kind;
		logic [15:0] out_track;
		logic [3:0]  out_first_block;
		logic [7:0]  out_block_count;
		logic [15:0] head_position;
	} rsp_t;

	// Stored list entry
	typedef struct packed {
		logic [5:0]  tag;
		logic        kind;
		logic [7:0]  count;
		logic [3:0]  first_block;
		logic [15:0] track;
	} entry_t;

endpackage

[sv/der_list_mem.sv]
// Sorted request list memory: one write port, one registered read port.
// Depends on der_pkg for the entry type.
module der_list_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  der_pkg::entry_t    wdata,
	input  logic [AW-1:0]      raddr,
	output der_pkg::entry_t    rdata
);

	der_pkg::entry_t mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/disk_elevator_request_scheduler.sv]
// Top level of the one-way elevator disk scheduler: sequencer, two list memories.
// Depends on der_pkg and der_list_mem.
//
//  channel | direction | payload          | handshake
//  req     | in        | der_pkg::req_t   | req_valid / req_stall
//  rsp     | out       | der_pkg::rsp_t   | rsp_valid / rsp_stall
//
// An enqueue runs a shift pass that walks the target list from its top entry
// down, one memory read and write per cycle, until the insert slot.
// A dispatch pops the list: the pop moves every entry down one place.
// Reset clears counts, head and list roles; list contents need no clearing.
// The result waits in an output register; a new request is taken once it is free.
module disk_elevator_request_scheduler #(
	parameter int unsigned LIST_DEPTH       = 16,
	parameter int unsigned BLOCKS_PER_TRACK = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  der_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output der_pkg::rsp_t   rsp
);

	localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
	// Reciprocal of the blocks per track, exact for dividends below 512
	localparam int unsigned RECIP_SH = 18;
	localparam logic [17:0] RECIP_M  = 18'((32'd1 << RECIP_SH) / BLOCKS_PER_TRACK + 32'd1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INS  = 5'b00010,
		S_POP  = 5'b00100,
		S_HEAD = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	der_pkg::entry_t ent_q;
	logic            tgt_b_q;
	logic [CW-1:0]   cnt_a_q, cnt_b_q;
	logic            cur_b_q;
	logic [15:0]     head_q;
	logic            known_q;
	logic [CW-1:0]   idx_q;
	logic            rd_pend_q;
	logic [CW-1:0]   pend_idx_q;
	logic            rsp_valid_q;
	der_pkg::rsp_t   rsp_q;

	logic            we_a, we_b;
	logic [AW-1:0]   waddr, raddr;
	der_pkg::entry_t wdata, rdata_a, rdata_b, rdata;

	der_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_a)
	);
	der_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_b)
	);

	assign rdata     = tgt_b_q ? rdata_b : rdata_a;
	assign req_stall = (state_q != S_IDLE) || rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	logic          accept;
	logic [CW-1:0] tcnt;
	logic          go_cur;
	logic [CW-1:0] pend_m1;

	assign accept  = req_valid && !req_stall;
	assign tcnt    = tgt_b_q ? cnt_b_q : cnt_a_q;
	assign go_cur  = !known_q || (head_q < req.req_track);
	assign pend_m1 = pend_idx_q - CW'(1);

	// Head travel: last track touched, saturated
	logic [16:0] trav;
	logic [8:0]  blk_sum;
	logic [8:0]  div_in;
	logic        skip_trk;
	logic [26:0] quo;
	logic [15:0] head_nx;
	always_comb begin
		blk_sum  = 9'(ent_q.first_block) + 9'(ent_q.count) - 9'd1;
		skip_trk = 32'(ent_q.first_block) >= BLOCKS_PER_TRACK;
		div_in   = skip_trk ? (9'(ent_q.count) - 9'd1) : blk_sum;
		quo      = 27'(div_in) * 27'(RECIP_M);
		if (ent_q.count == 8'd0) begin
			trav = 17'(ent_q.track);
		end else begin
			trav = 17'(ent_q.track) + 17'(skip_trk) + 17'(quo[26:RECIP_SH]);
		end
		head_nx = trav[16] ? der_pkg::TRACK_MAX : trav[15:0];
	end

	// Memory port control
	always_comb begin
		we_a  = 1'b0;
		we_b  = 1'b0;
		waddr = AW'(pend_idx_q);
		wdata = rdata;
		raddr = '0;
		priority case (1'b1)
			state_q == S_INS: begin
				// read entry idx-1; last data read goes to pend_idx
				raddr = AW'(idx_q - CW'(1));
				if (rd_pend_q) begin
					if (rdata.track <= ent_q.track) begin
						waddr = AW'(pend_idx_q);
						wdata = ent_q;
					end else begin
						waddr = AW'(pend_idx_q);
						wdata = rdata;
					end
					we_a = !tgt_b_q;
					we_b = tgt_b_q;
				end else if (idx_q == '0) begin
					waddr = '0;
					wdata = ent_q;
					we_a  = !tgt_b_q;
					we_b  = tgt_b_q;
				end
			end
			state_q == S_POP: begin
				raddr = AW'(idx_q);
				if (rd_pend_q && pend_idx_q != '0) begin
					waddr = AW'(pend_m1);
					wdata = rdata;
					we_a  = !tgt_b_q;
					we_b  = tgt_b_q;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			cur_b_q     <= 1'b0;
			head_q      <= '0;
			known_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			ent_q       <= '0;
			tgt_b_q     <= 1'b0;
			idx_q       <= '0;
			pend_idx_q  <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ent_q     <= '{tag: req.req_tag, kind: req.req_kind,
							count: req.req_block_count, first_block: req.req_first_block,
							track: req.req_track};
						rd_pend_q <= 1'b0;
						if (req.command == der_pkg::CMD_ENQUEUE) begin
							tgt_b_q <= go_cur ? cur_b_q : !cur_b_q;
							if ((go_cur ? (cur_b_q ? cnt_b_q : cnt_a_q)
							            : (cur_b_q ? cnt_a_q : cnt_b_q)) >= DEPTH_C) begin
								rsp_q   <= '{status: der_pkg::ST_FULL, head_position: head_q,
									default: '0};
								state_q <= S_DONE;
							end else begin
								idx_q   <= go_cur ? (cur_b_q ? cnt_b_q : cnt_a_q)
								                  : (cur_b_q ? cnt_a_q : cnt_b_q);
								rsp_q   <= '{status: der_pkg::ST_ENQUEUED, head_position: head_q,
									default: '0};
								state_q <= S_INS;
							end
						end else begin
							idx_q <= '0;
							if ((cur_b_q ? cnt_b_q : cnt_a_q) != '0) begin
								tgt_b_q <= cur_b_q;
								state_q <= S_POP;
							end else if ((cur_b_q ? cnt_a_q : cnt_b_q) != '0) begin
								cur_b_q <= !cur_b_q;
								tgt_b_q <= !cur_b_q;
								state_q <= S_POP;
							end else begin
								rsp_q   <= '{status: der_pkg::ST_IDLE, head_position: head_q,
									default: '0};
								state_q <= S_DONE;
							end
						end
					end
				end
				S_INS: begin
					// Shift larger entries up one place until the slot is found
					if (rd_pend_q && rdata.track <= ent_q.track) begin
						rd_pend_q <= 1'b0;
						state_q   <= S_DONE;
					end else if (!rd_pend_q && idx_q == '0) begin
						state_q <= S_DONE;
					end else if (idx_q == '0) begin
						// wrote last shifted entry at pend; slot 0 remains
						rd_pend_q  <= 1'b0;
						pend_idx_q <= '0;
					end else begin
						rd_pend_q  <= 1'b1;
						pend_idx_q <= idx_q;
						idx_q      <= idx_q - CW'(1);
					end
					if ((rd_pend_q && rdata.track <= ent_q.track)
					    || (!rd_pend_q && idx_q == '0)) begin
						if (tgt_b_q) cnt_b_q <= cnt_b_q + CW'(1);
						else         cnt_a_q <= cnt_a_q + CW'(1);
					end
				end
				S_POP: begin
					// Capture entry 0, then move each entry down one place
					if (rd_pend_q && pend_idx_q == '0) begin
						ent_q <= rdata;
					end
					if (idx_q == tcnt) begin
						rd_pend_q <= 1'b0;
						if (tgt_b_q) cnt_b_q <= cnt_b_q - CW'(1);
						else         cnt_a_q <= cnt_a_q - CW'(1);
						state_q <= S_HEAD;
					end else begin
						rd_pend_q  <= 1'b1;
						pend_idx_q <= idx_q;
						idx_q      <= idx_q + CW'(1);
					end
				end
				S_HEAD: begin
					head_q  <= head_nx;
					known_q <= 1'b1;
					rsp_q   <= '{status: der_pkg::ST_DISPATCH, out_tag: ent_q.tag,
						out_kind: ent_q.kind, out_track: ent_q.track,
						out_first_block: ent_q.first_block, out_block_count: ent_q.count,
						head_position: head_nx};
					state_q <= S_DONE;
				end
				S_DONE: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/der_checker.sv]
// Port checker for the elevator scheduler, bound to the top level.
// Depends on der_pkg for the payload types.
module der_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input der_pkg::rsp_t rsp
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// Take no request while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while result pending");

	// Non-dispatch results carry zero fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != der_pkg::ST_DISPATCH |-> rsp.out_tag == '0
		&& rsp.out_track == '0 && rsp.out_block_count == '0)
		else $error("non-dispatch result carries data");

	// A request is followed by no result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !rsp_valid)
		else $error("result too early");

endmodule

bind disk_elevator_request_scheduler der_checker u_der_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);

[verif/disk_elevator_request_scheduler_test.sv]
// Self-checking testbench for the one-way elevator disk scheduler.
// Depends on der_pkg and disk_elevator_request_scheduler; predicts every result in-line.
module disk_elevator_request_scheduler_test;

	localparam int DEPTH = 16;
	localparam int BPT   = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	// Expected-result store and comparison
	class sched_scoreboard;
		der_pkg::rsp_t pending_rsps[$];
		int   errors;

		function void note_request(der_pkg::rsp_t r);
			pending_rsps.push_back(r);
		endfunction

		function void check_result(der_pkg::rsp_t got);
			der_pkg::rsp_t exp_r;
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending_rsps.pop_front();
			if (got.status != exp_r.status) begin
				$display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
				errors++;
			end
			if (got.out_tag != exp_r.out_tag) begin
				$display("%0t: out_tag exp %0d got %0d", $time, exp_r.out_tag, got.out_tag);
				errors++;
			end
			if (got.out_kind != exp_r.out_kind) begin
				$display("%0t: out_kind exp %0d got %0d", $time, exp_r.out_kind,
					got.out_kind);
				errors++;
			end
			if (got.out_track != exp_r.out_track) begin
				$display("%0t: out_track exp %0d got %0d", $time, exp_r.out_track,
					got.out_track);
				errors++;
			end
			if (got.out_first_block != exp_r.out_first_block) begin
				$display("%0t: out_first_block exp %0d got %0d", $time,
					exp_r.out_first_block, got.out_first_block);
				errors++;
			end
			if (got.out_block_count != exp_r.out_block_count) begin
				$display("%0t: out_block_count exp %0d got %0d", $time,
					exp_r.out_block_count, got.out_block_count);
				errors++;
			end
			if (got.head_position != exp_r.head_position) begin
				$display("%0t: head_position exp %0d got %0d", $time,
					exp_r.head_position, got.head_position);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	der_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_stall;
	der_pkg::rsp_t  rsp;

	sched_scoreboard sb;
	int idle_cycles;

	// Predicted scheduler state
	der_pkg::entry_t sweep_lists[2][DEPTH];
	int     sweep_len[2];
	int     cur_sweep;
	logic [15:0] head_trk;
	bit     head_valid;

	disk_elevator_request_scheduler #(.LIST_DEPTH(DEPTH), .BLOCKS_PER_TRACK(BPT)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Track the head finishes on, saturating at the top track
	function automatic logic [15:0] end_track(der_pkg::entry_t e);
		int last;
		if (e.count == 0) return e.track;
		if (e.first_block >= BPT)
			last = e.track + 1 + (e.count - 1) / BPT;
		else
			last = e.track + (e.first_block + e.count - 1) / BPT;
		return (last > 65535) ? 16'hFFFF : last[15:0];
	endfunction

	// Advance the predicted state by one request and return its result
	function automatic der_pkg::rsp_t schedule_step(der_pkg::req_t r);
		der_pkg::rsp_t   res;
		der_pkg::entry_t e;
		int     tl, pos;
		res = '0;
		if (r.command == der_pkg::CMD_ENQUEUE) begin
			e = '{tag: r.req_tag, kind: r.req_kind, count: r.req_block_count,
				first_block: r.req_first_block, track: r.req_track};
			tl = (!head_valid || head_trk < r.req_track) ? cur_sweep : 1 - cur_sweep;
			if (sweep_len[tl] >= DEPTH) begin
				res.status = der_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < sweep_len[tl] && sweep_lists[tl][pos].track <= e.track)
					pos++;
				for (int i = sweep_len[tl]; i > pos; i--)
					sweep_lists[tl][i] = sweep_lists[tl][i-1];
				sweep_lists[tl][pos] = e;
				sweep_len[tl]++;
				res.status = der_pkg::ST_ENQUEUED;
			end
		end else begin
			if (sweep_len[cur_sweep] == 0 && sweep_len[1-cur_sweep] != 0)
				cur_sweep = 1 - cur_sweep;
			if (sweep_len[cur_sweep] == 0) begin
				res.status = der_pkg::ST_IDLE;
			end else begin
				e = sweep_lists[cur_sweep][0];
				for (int i = 1; i < sweep_len[cur_sweep]; i++)
					sweep_lists[cur_sweep][i-1] = sweep_lists[cur_sweep][i];
				sweep_len[cur_sweep]--;
				res.status = der_pkg::ST_DISPATCH;
				res.out_tag = e.tag;
				res.out_kind = e.kind;
				res.out_track = e.track;
				res.out_first_block = e.first_block;
				res.out_block_count = e.count;
				head_trk = end_track(e);
				head_valid = 1'b1;
			end
		end
		res.head_position = head_trk;
		return res;
	endfunction

	// No gap half the time, else mostly a short one, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Present one request, hold it until accepted, then note the prediction
	task automatic send_request(der_pkg::req_t r);
		int g;
		g = gap_len();
		if (g != 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(schedule_step(r));
	endtask

	task automatic send_enqueue(logic [15:0] trk, logic [3:0] fb, logic [7:0] cnt,
		logic kind, logic [5:0] tag);
		der_pkg::req_t r;
		r = '{command: der_pkg::CMD_ENQUEUE, req_track: trk, req_first_block: fb,
			req_block_count: cnt, req_kind: kind, req_tag: tag};
		send_request(r);
	endtask

	task automatic send_dispatch();
		der_pkg::req_t r;
		r = '0;
		r.command = der_pkg::CMD_DISPATCH;
		r.req_track = 16'($urandom);
		r.req_tag = 6'($urandom);
		send_request(r);
	endtask

	// Random enqueue, tracks mostly clustered near the head so both lists fill
	task automatic random_enqueue();
		logic [15:0] trk;
		int p;
		p = $urandom_range(99);
		if (p < 60) trk = 16'(head_trk + $urandom_range(40) - 20);
		else if (p < 70) trk = head_trk;
		else if (p < 75) trk = 16'(16'hFFFF - $urandom_range(3));
		else trk = 16'($urandom);
		send_enqueue(trk, 4'($urandom), ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom),
			1'($urandom), 6'($urandom));
	endtask

	// Drop the request and wait until every predicted result has been seen
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending_rsps.size() != 0) @(posedge clk);
	endtask

	// Result side: random stall, check each accepted transaction
	initial begin
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) sb.check_result(rsp);
			rsp_stall <= (gap_len() != 0) && ($urandom_range(2) != 0);
		end
	end

	// Watchdog on cycles with no transaction on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		sb = new();
		sweep_len[0] = 0;
		sweep_len[1] = 0;
		cur_sweep = 0;
		head_trk = '0;
		head_valid = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dispatch, unknown head, extremes, zero count, overflow
		send_dispatch();
		send_enqueue(16'd0, 4'd0, 8'd0, 1'b0, 6'd0);
		send_enqueue(16'hFFFF, 4'hF, 8'hFF, 1'b1, 6'h3F);
		send_enqueue(16'd100, 4'hF, 8'd1, 1'b1, 6'd5);
		send_enqueue(16'd100, 4'd3, 8'd17, 1'b0, 6'd6);
		send_dispatch();
		send_dispatch();
		send_dispatch();
		send_enqueue(16'd50, 4'd1, 8'd16, 1'b0, 6'd7);
		send_enqueue(16'd101, 4'd2, 8'd4, 1'b1, 6'd8);
		send_dispatch();
		send_dispatch();
		send_dispatch();
		send_dispatch();
		// Fill the next list until it reports full
		for (int i = 0; i < DEPTH + 2; i++)
			send_enqueue(16'd10 + i[15:0] % 3, i[3:0], 8'(i), i[0], 6'(i));
		drain();
		repeat (40) @(posedge clk);
		for (int i = 0; i < DEPTH + 2; i++)
			send_dispatch();

		// Random: bursts of enqueues and dispatches
		for (int n = 0; n < 900; n++) begin
			if ($urandom_range(3) < 2 && n % 200 > 100) random_enqueue();
			else if ($urandom_range(1) == 0) random_enqueue();
			else send_dispatch();
			if (n == 500) begin
				drain();
				repeat (40) @(posedge clk);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsps.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
sv/der_pkg.sv
sv/der_list_mem.sv
sv/disk_elevator_request_scheduler.sv
sv/der_checker.sv
verif/disk_elevator_request_scheduler_test.sv
